/* rtl/mvsm_pkg.sv */
package mvsm_pkg;

    localparam int VOICE_SLOTS  = 8;
    localparam int SLOT_W       = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
    localparam int BLOCK_TICKS  = 512;
    localparam int CNT_W        = (BLOCK_TICKS > 1) ? $clog2(BLOCK_TICKS) : 1;
    localparam int SAMPLE_DEPTH = 65536;
    localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
    localparam int LEN_W        = 17;
    localparam int VOL_W        = 7;
    localparam int SCALED_W     = 24;
    localparam int SUM_W        = 28;

    localparam logic signed [SUM_W-1:0] CLIP_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] CLIP_LO = -SUM_W'(32767);

    // Exact division by 100 for magnitudes below 2^32: (m * MAGIC) >> 37.
    localparam logic [30:0] DIV_MAGIC = 31'd1374389535;
    localparam int          DIV_SHIFT = 37;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_START = 2'd1,
        KIND_TICK  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_TOTAL    = 2'd0,
        CFG_MUSIC    = 2'd1,
        CFG_EFFECT   = 2'd2,
        CFG_MUSIC_EN = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VREAD,
        ST_VEVAL,
        ST_SAMPLE,
        ST_WAIT,
        ST_MIX_DONE,
        ST_BE_READ,
        ST_BE_EVAL
    } t_state;

    typedef struct packed {
        logic              music;
        logic              loop;
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] position;
        logic [LEN_W-1:0]  remaining;
    } t_voice;

endpackage

/* rtl/mvsm_scale.sv */
module mvsm_scale (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic signed [15:0]                    i_sample,
    input  logic [mvsm_pkg::VOL_W-1:0]            i_total,
    input  logic [mvsm_pkg::VOL_W-1:0]            i_class,
    output logic                                  o_valid,
    output logic signed [mvsm_pkg::SCALED_W-1:0]  o_scaled
);
    import mvsm_pkg::*;

    logic [2:0]                 r_valid;
    logic signed [23:0]         r_p1;
    logic [VOL_W-1:0]           r_class;
    logic signed [31:0]         r_p2;
    logic [60:0]                r_prod;
    logic                       r_neg;
    logic [29:0]                mag;
    logic [SCALED_W-1:0]        quot;

    always_comb begin
        mag = r_p2[31] ? 30'(-r_p2) : r_p2[29:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1    <= 24'(i_sample) * 24'($signed({1'b0, i_total}));
        r_class <= i_class;
        r_p2    <= 32'(r_p1) * 32'($signed({1'b0, r_class}));
        r_prod  <= 61'(mag) * 61'(DIV_MAGIC);
        r_neg   <= r_p2[31];
    end

    assign quot     = r_prod[DIV_SHIFT +: SCALED_W];
    assign o_valid  = r_valid[2];
    assign o_scaled = r_neg ? -$signed(quot) : $signed(quot);

endmodule

/* rtl/multi_voice_sample_mixer_core.sv */
// Channel   Direction  Handshake               Payload
// item      in         start high, busy low    i_kind, i_address, i_sample_word,
//                                              i_sound_length, i_is_music, i_loop_flag
// result    out        o_result_strobe, 1 cyc  o_mixed_sample, o_sample_valid,
//                                              o_start_rejected
// config    in         i_cfg_we                i_cfg_index, i_cfg_data
//
// Write, start and any other non-tick kind strobe their result in the next cycle.
// A tick walks the voice table one slot at a time: a slot is read and evaluated, and a
// playing slot then fetches its sample and waits for the scaler; every BLOCK_TICKS-th
// tick adds a pass that restarts or frees stopped voices. busy is high meanwhile.
// Reset is synchronous and clears the voice flags, block counter, state and strobe.
// The receiver cannot stall; each result is shown for one cycle only.
module multi_voice_sample_mixer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_kind,
    input  logic [15:0]                       i_address,
    input  logic signed [15:0]                i_sample_word,
    input  logic [mvsm_pkg::LEN_W-1:0]        i_sound_length,
    input  logic                              i_is_music,
    input  logic                              i_loop_flag,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [mvsm_pkg::VOL_W-1:0]        i_cfg_data,
    output logic                              o_result_strobe,
    output logic signed [15:0]                o_mixed_sample,
    output logic                              o_sample_valid,
    output logic                              o_start_rejected
);
    import mvsm_pkg::*;

    t_state                     r_state, n_state;
    logic [SLOT_W-1:0]          r_slot;
    logic [VOICE_SLOTS-1:0]     r_used;
    logic [VOICE_SLOTS-1:0]     r_playing;
    logic [CNT_W-1:0]           r_cnt;
    logic signed [SUM_W-1:0]    r_sum;
    logic [VOL_W-1:0]           r_total_vol;
    logic [VOL_W-1:0]           r_music_vol;
    logic [VOL_W-1:0]           r_effect_vol;
    logic                       r_music_en;
    logic                       r_strobe;
    logic signed [15:0]         r_mixed;
    logic                       r_sval;
    logic                       r_rej;

    t_voice                     r_vmem [VOICE_SLOTS];
    t_voice                     r_vrd;
    logic [15:0]                r_smem [SAMPLE_DEPTH];
    logic [15:0]                r_smp;

    logic                       accept;
    logic                       free_found;
    logic [SLOT_W-1:0]          free_idx;
    logic                       slot_last;
    logic                       v_active;
    logic                       ev_stop;
    logic                       ev_play;
    logic                       be_stopped;
    logic [CNT_W:0]             cnt_inc;
    logic                       block_end;

    logic                       smem_we;
    logic                       vmem_we;
    logic [SLOT_W-1:0]          vmem_waddr;
    t_voice                     vmem_wdata;
    logic                       scale_valid;
    logic                       scale_done;
    logic signed [SCALED_W-1:0] scaled;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [15:0]         clipped;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = VOICE_SLOTS - 1; s >= 0; s--) begin
            if (!r_used[s]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(s);
            end
        end
    end

    assign slot_last  = (r_slot == SLOT_W'(VOICE_SLOTS - 1));
    assign v_active   = r_used[r_slot] && r_playing[r_slot];
    assign ev_stop    = v_active && (r_vrd.remaining == '0);
    assign ev_play    = v_active && (r_vrd.remaining != '0) && !(r_vrd.music && !r_music_en);
    assign be_stopped = r_used[r_slot] && !r_playing[r_slot];
    assign cnt_inc    = {1'b0, r_cnt} + 1'b1;
    assign block_end  = (cnt_inc == (CNT_W + 1)'(BLOCK_TICKS));
    assign sum_next   = r_sum + SUM_W'(scaled);

    always_comb begin
        if (r_sum > CLIP_HI) begin
            clipped = CLIP_HI[15:0];
        end else if (r_sum < CLIP_LO) begin
            clipped = CLIP_LO[15:0];
        end else begin
            clipped = r_sum[15:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_kind == KIND_TICK)) begin
                    n_state = ST_VREAD;
                end
            end
            ST_VREAD: begin
                n_state = ST_VEVAL;
            end
            ST_VEVAL: begin
                if (ev_play) begin
                    n_state = ST_SAMPLE;
                end else if (slot_last) begin
                    n_state = ST_MIX_DONE;
                end else begin
                    n_state = ST_VREAD;
                end
            end
            ST_SAMPLE: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (scale_done) begin
                    n_state = slot_last ? ST_MIX_DONE : ST_VREAD;
                end
            end
            ST_MIX_DONE: begin
                n_state = block_end ? ST_BE_READ : ST_IDLE;
            end
            ST_BE_READ: begin
                n_state = ST_BE_EVAL;
            end
            ST_BE_EVAL: begin
                n_state = slot_last ? ST_IDLE : ST_BE_READ;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        smem_we     = 1'b0;
        vmem_we     = 1'b0;
        vmem_waddr  = r_slot;
        vmem_wdata  = r_vrd;
        scale_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_kind == KIND_WRITE)) begin
                    smem_we = 1'b1;
                end
                if (accept && (i_kind == KIND_START) && free_found) begin
                    vmem_we              = 1'b1;
                    vmem_waddr           = free_idx;
                    vmem_wdata.music     = i_is_music;
                    vmem_wdata.loop      = i_loop_flag;
                    vmem_wdata.start     = i_address[ADDR_W-1:0];
                    vmem_wdata.length    = i_sound_length;
                    vmem_wdata.position  = i_address[ADDR_W-1:0];
                    vmem_wdata.remaining = i_sound_length;
                end
            end
            ST_VEVAL: begin
                if (ev_play) begin
                    vmem_we              = 1'b1;
                    vmem_wdata.position  = r_vrd.position + 1'b1;
                    vmem_wdata.remaining = r_vrd.remaining - 1'b1;
                end
            end
            ST_SAMPLE: begin
                scale_valid = 1'b1;
            end
            ST_BE_EVAL: begin
                if (be_stopped && r_vrd.loop) begin
                    vmem_we              = 1'b1;
                    vmem_wdata.position  = r_vrd.start;
                    vmem_wdata.remaining = r_vrd.length;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (vmem_we) begin
            r_vmem[vmem_waddr] <= vmem_wdata;
        end
        r_vrd <= r_vmem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (smem_we) begin
            r_smem[i_address[ADDR_W-1:0]] <= i_sample_word;
        end
        r_smp <= r_smem[r_vrd.position];
    end

    mvsm_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (scale_valid),
        .i_sample ($signed(r_smp)),
        .i_total  (r_total_vol),
        .i_class  (r_vrd.music ? r_music_vol : r_effect_vol),
        .o_valid  (scale_done),
        .o_scaled (scaled)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_slot       <= '0;
            r_used       <= '0;
            r_playing    <= '0;
            r_cnt        <= '0;
            r_sum        <= '0;
            r_total_vol  <= VOL_W'(100);
            r_music_vol  <= VOL_W'(100);
            r_effect_vol <= VOL_W'(100);
            r_music_en   <= 1'b1;
            r_strobe     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (accept && (i_kind != KIND_TICK)) || (r_state == ST_MIX_DONE);

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TOTAL:    r_total_vol  <= i_cfg_data;
                    CFG_MUSIC:    r_music_vol  <= i_cfg_data;
                    CFG_EFFECT:   r_effect_vol <= i_cfg_data;
                    CFG_MUSIC_EN: r_music_en   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_slot <= '0;
                        r_sum  <= '0;
                        if ((i_kind == KIND_START) && free_found) begin
                            r_used[free_idx]    <= 1'b1;
                            r_playing[free_idx] <= 1'b1;
                        end
                    end
                end
                ST_VEVAL: begin
                    if (ev_stop) begin
                        r_playing[r_slot] <= 1'b0;
                    end
                    if (!ev_play && !slot_last) begin
                        r_slot <= r_slot + 1'b1;
                    end
                end
                ST_WAIT: begin
                    if (scale_done) begin
                        r_sum <= sum_next;
                        if (!slot_last) begin
                            r_slot <= r_slot + 1'b1;
                        end
                    end
                end
                ST_MIX_DONE: begin
                    r_slot   <= '0;
                    r_cnt    <= block_end ? '0 : cnt_inc[CNT_W-1:0];
                end
                ST_BE_EVAL: begin
                    if (be_stopped) begin
                        if (r_vrd.loop) begin
                            r_playing[r_slot] <= 1'b1;
                        end else begin
                            r_used[r_slot] <= 1'b0;
                        end
                    end
                    if (!slot_last) begin
                        r_slot <= r_slot + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MIX_DONE) begin
            r_mixed <= clipped;
            r_sval  <= 1'b1;
            r_rej   <= 1'b0;
        end else if (accept) begin
            r_mixed <= '0;
            r_sval  <= 1'b0;
            r_rej   <= (i_kind == KIND_START) && !free_found;
        end
    end

    assign o_result_strobe  = r_strobe;
    assign o_mixed_sample   = r_mixed;
    assign o_sample_valid   = r_sval;
    assign o_start_rejected = r_rej;

endmodule
